// ===== rtl/ray_triangle_intersect_test_core_assert.svh =====
// ----------------------------------------------------------------------------
// Ray/triangle test assertion macros
// Concurrent assertion wrappers clocked on clk, one held off during reset and one checked always.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_TEST_CORE_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_TEST_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset
`define RTI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define RTI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray/triangle test package
// Field widths, register indexes, outcome codes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rti_pkg;

    localparam int FIELD_WIDTH     = 32;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int EPS_WIDTH       = 63;
    localparam int OUTCOME_WIDTH   = 2;
    localparam int LATENCY         = 8;

    localparam logic [FIELD_WIDTH-1:0] DIR_Z_RESET = 32'h0001_0000;
    localparam logic [EPS_WIDTH-1:0]   EPS_RESET   = 63'd2814749767;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_EPS      = 3'd6
    } cfg_index_t;

    typedef enum logic [OUTCOME_WIDTH-1:0] {
        OUT_PARALLEL = 2'd0,
        OUT_MISS     = 2'd1,
        OUT_HIT      = 2'd2
    } outcome_t;

endpackage

// ===== rtl/ray_triangle_intersect_test_core.sv =====
// ----------------------------------------------------------------------------
// Throughput: one triangle per cycle; busy stays low, no back-pressure.
// Eight register stages: differences, products, cross, partial products,
// terms, dot sums, sign/magnitude, outcome.
// Reset clears stage valids and loads the ray registers with their defaults.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// Ray/triangle intersection test core
// Exact fixed-point plane and barycentric test of a stream of triangles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_triangle_intersect_test_core
    import rti_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       start,
    output logic                       busy,
    input  logic [FIELD_WIDTH-1:0]     vertex_a_x,
    input  logic [FIELD_WIDTH-1:0]     vertex_a_y,
    input  logic [FIELD_WIDTH-1:0]     vertex_a_z,
    input  logic [FIELD_WIDTH-1:0]     vertex_b_x,
    input  logic [FIELD_WIDTH-1:0]     vertex_b_y,
    input  logic [FIELD_WIDTH-1:0]     vertex_b_z,
    input  logic [FIELD_WIDTH-1:0]     vertex_c_x,
    input  logic [FIELD_WIDTH-1:0]     vertex_c_y,
    input  logic [FIELD_WIDTH-1:0]     vertex_c_z,
    output logic                       done,
    output logic [OUTCOME_WIDTH-1:0]   outcome
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int CW = PW + 1;
    localparam int LW = W + 2;
    localparam int HW = CW - LW;
    localparam int TW = CW + DW;
    localparam int SW = TW + 2;
    localparam int MW = (SW > EPS_WIDTH) ? SW : EPS_WIDTH;

    logic signed [W-1:0]         origin_reg [3];
    logic signed [W-1:0]         dir_reg [3];
    logic [EPS_WIDTH-1:0]        eps_reg;

    logic [LATENCY-1:0]          valid_reg;
    logic [LATENCY-1:0]          valid_next;
    logic                        accept;

    logic signed [W-1:0]         va [3];
    logic signed [W-1:0]         vb [3];
    logic signed [W-1:0]         vc [3];

    logic signed [DW-1:0]        e1_reg [3];
    logic signed [DW-1:0]        e2_reg [3];
    logic signed [DW-1:0]        pa_reg [3];
    logic signed [DW-1:0]        pb_reg [3];
    logic signed [DW-1:0]        pc_reg [3];

    logic signed [PW-1:0]        pl_reg [4][3];
    logic signed [PW-1:0]        pr_reg [4][3];
    logic signed [DW-1:0]        pa2_reg [3];

    logic signed [CW-1:0]        cr_reg [4][3];
    logic signed [DW-1:0]        pa3_reg [3];

    logic signed [LW+DW:0]       lo_reg [5][3];
    logic signed [HW+DW-1:0]     hi_reg [5][3];

    logic signed [TW-1:0]        term_reg [5][3];
    logic signed [SW-1:0]        sum_reg [5];

    logic                        den_zero_reg;
    logic                        miss_reg;
    logic                        miss_next;
    logic [SW-1:0]               mag_reg;

    logic [OUTCOME_WIDTH-1:0]    outcome_reg;
    logic [OUTCOME_WIDTH-1:0]    outcome_next;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign accept    = start && !busy;

    assign va[0] = vertex_a_x[W-1:0];
    assign va[1] = vertex_a_y[W-1:0];
    assign va[2] = vertex_a_z[W-1:0];
    assign vb[0] = vertex_b_x[W-1:0];
    assign vb[1] = vertex_b_y[W-1:0];
    assign vb[2] = vertex_b_z[W-1:0];
    assign vc[0] = vertex_c_x[W-1:0];
    assign vc[1] = vertex_c_y[W-1:0];
    assign vc[2] = vertex_c_z[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            dir_reg[0]    <= '0;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= DIR_Z_RESET[W-1:0];
            eps_reg       <= EPS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ORIGIN_X: origin_reg[0] <= cfg_data[W-1:0];
                REG_ORIGIN_Y: origin_reg[1] <= cfg_data[W-1:0];
                REG_ORIGIN_Z: origin_reg[2] <= cfg_data[W-1:0];
                REG_DIR_X:    dir_reg[0]    <= cfg_data[W-1:0];
                REG_DIR_Y:    dir_reg[1]    <= cfg_data[W-1:0];
                REG_DIR_Z:    dir_reg[2]    <= cfg_data[W-1:0];
                REG_EPS:      eps_reg       <= cfg_data[EPS_WIDTH-1:0];
                default:      ;
            endcase
        end
    end

    assign valid_next = {valid_reg[LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        miss_next = 1'b0;
        for (int k = 1; k < 5; k++)
        begin
            if ((sum_reg[k] != '0) && (sum_reg[k][SW-1] != sum_reg[0][SW-1]))
            begin
                miss_next = 1'b1;
            end
        end
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_reg[i] <= DW'(vb[i]) - DW'(va[i]);
            e2_reg[i] <= DW'(vc[i]) - DW'(va[i]);
            pa_reg[i] <= DW'(va[i]) - DW'(origin_reg[i]);
            pb_reg[i] <= DW'(vb[i]) - DW'(origin_reg[i]);
            pc_reg[i] <= DW'(vc[i]) - DW'(origin_reg[i]);
        end

        for (int i = 0; i < 3; i++)
        begin
            pl_reg[0][i] <= PW'(e1_reg[(i+1)%3]) * PW'(e2_reg[(i+2)%3]);
            pr_reg[0][i] <= PW'(e1_reg[(i+2)%3]) * PW'(e2_reg[(i+1)%3]);
            pl_reg[1][i] <= PW'(pb_reg[(i+1)%3]) * PW'(pc_reg[(i+2)%3]);
            pr_reg[1][i] <= PW'(pb_reg[(i+2)%3]) * PW'(pc_reg[(i+1)%3]);
            pl_reg[2][i] <= PW'(pc_reg[(i+1)%3]) * PW'(pa_reg[(i+2)%3]);
            pr_reg[2][i] <= PW'(pc_reg[(i+2)%3]) * PW'(pa_reg[(i+1)%3]);
            pl_reg[3][i] <= PW'(pa_reg[(i+1)%3]) * PW'(pb_reg[(i+2)%3]);
            pr_reg[3][i] <= PW'(pa_reg[(i+2)%3]) * PW'(pb_reg[(i+1)%3]);
            pa2_reg[i]   <= pa_reg[i];
        end

        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                cr_reg[k][i] <= CW'(pl_reg[k][i]) - CW'(pr_reg[k][i]);
            end
            pa3_reg[i] <= pa2_reg[i];
        end

        // Split each cross component into an unsigned low and signed high part
        for (int i = 0; i < 3; i++)
        begin
            lo_reg[0][i] <= $signed({1'b0, cr_reg[0][i][LW-1:0]}) * DW'(dir_reg[i]);
            hi_reg[0][i] <= $signed(cr_reg[0][i][CW-1:LW]) * DW'(dir_reg[i]);
            lo_reg[1][i] <= $signed({1'b0, cr_reg[0][i][LW-1:0]}) * pa3_reg[i];
            hi_reg[1][i] <= $signed(cr_reg[0][i][CW-1:LW]) * pa3_reg[i];
            for (int k = 1; k < 4; k++)
            begin
                lo_reg[k+1][i] <= $signed({1'b0, cr_reg[k][i][LW-1:0]})
                                  * DW'(dir_reg[i]);
                hi_reg[k+1][i] <= $signed(cr_reg[k][i][CW-1:LW]) * DW'(dir_reg[i]);
            end
        end

        for (int k = 0; k < 5; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                term_reg[k][i] <= (TW'(hi_reg[k][i]) <<< LW) + TW'(lo_reg[k][i]);
            end
            sum_reg[k] <= SW'(term_reg[k][0]) + SW'(term_reg[k][1])
                          + SW'(term_reg[k][2]);
        end

        den_zero_reg <= (sum_reg[0] == '0);
        mag_reg      <= sum_reg[0][SW-1] ? SW'(-sum_reg[0]) : SW'(sum_reg[0]);
        miss_reg     <= miss_next;

        outcome_reg <= outcome_next;
    end

    always_comb
    begin
        if (den_zero_reg || (MW'(mag_reg) < MW'(eps_reg)))
        begin
            outcome_next = OUT_PARALLEL;
        end
        else if (miss_reg)
        begin
            outcome_next = OUT_MISS;
        end
        else
        begin
            outcome_next = OUT_HIT;
        end
    end

    assign done    = valid_reg[LATENCY-1];
    assign outcome = outcome_reg;

endmodule

// ===== rtl/rti_checker.sv =====
// ----------------------------------------------------------------------------
// Ray/triangle test checker
// Port-level assertions on latency, codes and the always-ready handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ray_triangle_intersect_test_core_assert.svh"

module rti_checker
    import rti_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     cfg_ready,
    input logic                     start,
    input logic                     busy,
    input logic                     done,
    input logic [OUTCOME_WIDTH-1:0] outcome
);

    `RTI_ASSERT(a_done_latency, done |-> $past(start && !busy, LATENCY), "done without item")
    `RTI_ASSERT(a_item_done, (start && !busy) |-> ##LATENCY done, "item lost")
    `RTI_ASSERT(a_outcome_code, done |-> (outcome != 2'd3), "bad outcome code")
    `RTI_ASSERT_ALWAYS(a_never_stall, !busy && cfg_ready, "stall raised")

endmodule

bind ray_triangle_intersect_test_core rti_checker u_rti_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg_ready),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .outcome   (outcome)
);

// ===== tb/sv/ray_triangle_intersect_test_core_tb.sv =====
// ----------------------------------------------------------------------------
// Ray/triangle test core testbench
// Streams triangles through the core under several ray and epsilon settings.
// Each outcome is checked against an exact 128-bit plane/barycentric model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_triangle_intersect_test_core_tb;
    import rti_pkg::*;

    typedef logic signed [127:0] wide_t;
    typedef struct packed { wide_t x; wide_t y; wide_t z; } vec_t;
    typedef struct packed {
        logic [FIELD_WIDTH-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    } tri_t;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 200000;

    class outcome_board;
        outcome_t pending[$];
        int       errors;
        int       seen;
        int       hits[3];

        function void note(outcome_t o);
            pending.push_back(o);
        endfunction

        function void check(logic [OUTCOME_WIDTH-1:0] got);
            outcome_t want;
            if (pending.size() == 0)
            begin
                $error("outcome: no item waiting, actual %0d", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            seen++;
            if (want <= OUT_HIT)
                hits[want]++;
            if (got !== want)
            begin
                $error("outcome: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;
    logic                       start;
    logic                       busy;
    logic [FIELD_WIDTH-1:0]     vertex_a_x, vertex_a_y, vertex_a_z;
    logic [FIELD_WIDTH-1:0]     vertex_b_x, vertex_b_y, vertex_b_z;
    logic [FIELD_WIDTH-1:0]     vertex_c_x, vertex_c_y, vertex_c_z;
    logic                       done;
    logic [OUTCOME_WIDTH-1:0]   outcome;

    outcome_board board;
    logic [FIELD_WIDTH-1:0] ray_origin[3];
    logic [FIELD_WIDTH-1:0] ray_dir[3];
    logic [EPS_WIDTH-1:0]   ray_eps;
    int  cycles = 0;
    int  sent;

    ray_triangle_intersect_test_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .vertex_a_x(vertex_a_x), .vertex_a_y(vertex_a_y), .vertex_a_z(vertex_a_z),
        .vertex_b_x(vertex_b_x), .vertex_b_y(vertex_b_y), .vertex_b_z(vertex_b_z),
        .vertex_c_x(vertex_c_x), .vertex_c_y(vertex_c_y), .vertex_c_z(vertex_c_z),
        .done(done), .outcome(outcome)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic wide_t widen(logic [FIELD_WIDTH-1:0] r);
        return wide_t'(signed'(r));
    endfunction

    function automatic vec_t vsub(vec_t a, vec_t b);
        vec_t r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    function automatic vec_t vcross(vec_t a, vec_t b);
        vec_t r;
        r.x = a.y * b.z - a.z * b.y;
        r.y = a.z * b.x - a.x * b.z;
        r.z = a.x * b.y - a.y * b.x;
        return r;
    endfunction

    function automatic wide_t vdot(vec_t a, vec_t b);
        return a.x * b.x + a.y * b.y + a.z * b.z;
    endfunction

    function automatic bit against(wide_t num, wide_t den);
        return num != 0 && ((num < 0) != (den < 0));
    endfunction

    function automatic outcome_t predict_outcome(tri_t t);
        vec_t  a, b, c, p, d, n, pa, pb, pc;
        wide_t den;
        logic [127:0] mag;
        a = '{widen(t.ax), widen(t.ay), widen(t.az)};
        b = '{widen(t.bx), widen(t.by), widen(t.bz)};
        c = '{widen(t.cx), widen(t.cy), widen(t.cz)};
        p = '{widen(ray_origin[0]), widen(ray_origin[1]), widen(ray_origin[2])};
        d = '{widen(ray_dir[0]), widen(ray_dir[1]), widen(ray_dir[2])};
        n = vcross(vsub(b, a), vsub(c, a));
        den = vdot(n, d);
        mag = (den < 0) ? -den : den;
        if (den == 0 || mag < {65'd0, ray_eps})
            return OUT_PARALLEL;
        pa = vsub(a, p);
        pb = vsub(b, p);
        pc = vsub(c, p);
        if (against(vdot(pa, n), den) || against(vdot(d, vcross(pb, pc)), den) ||
            against(vdot(d, vcross(pc, pa)), den) || against(vdot(d, vcross(pa, pb)), den))
            return OUT_MISS;
        return OUT_HIT;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check(outcome);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic settle();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // hold valid high across consecutive writes; the caller drops it
    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_ORIGIN_X: ray_origin[0] = val[FIELD_WIDTH-1:0];
            REG_ORIGIN_Y: ray_origin[1] = val[FIELD_WIDTH-1:0];
            REG_ORIGIN_Z: ray_origin[2] = val[FIELD_WIDTH-1:0];
            REG_DIR_X:    ray_dir[0]    = val[FIELD_WIDTH-1:0];
            REG_DIR_Y:    ray_dir[1]    = val[FIELD_WIDTH-1:0];
            REG_DIR_Z:    ray_dir[2]    = val[FIELD_WIDTH-1:0];
            REG_EPS:      ray_eps       = val[EPS_WIDTH-1:0];
            default:      ;
        endcase
    endtask

    task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz, logic [63:0] eps);
        settle();
        write_reg(REG_ORIGIN_X, {$urandom, ox});
        write_reg(REG_ORIGIN_Y, {$urandom, oy});
        write_reg(REG_ORIGIN_Z, {$urandom, oz});
        write_reg(REG_DIR_X, {$urandom, dx});
        write_reg(REG_DIR_Y, {$urandom, dy});
        write_reg(REG_DIR_Z, {$urandom, dz});
        write_reg(REG_EPS, eps);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    // hold start high across back-to-back items, drop it only for a gap
    task automatic send(tri_t t);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        {vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
         vertex_c_x, vertex_c_y, vertex_c_z} <= t;
        do
            @(posedge clk);
        while (busy);
        board.note(predict_outcome(t));
        sent++;
    endtask

    task automatic finish_burst();
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] near(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic tri_t random_tri();
        tri_t t;
        int   kind;
        int   span;
        kind = $urandom_range(0, 9);
        span = 1 << $urandom_range(4, 20);
        t = {near(span), near(span), near(span), near(span), near(span),
             near(span), near(span), near(span), near(span)};
        if (kind < 2)
            t = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        else if (kind == 2)
            {t.cx, t.cy, t.cz} = {t.bx, t.by, t.bz};
        else if (kind == 3)
            {t.ax, t.ay, t.az} = {ray_origin[0], ray_origin[1], ray_origin[2]};
        else if (kind == 4)
            {t.bx, t.by, t.bz} = {t.ax + ray_dir[0], t.ay + ray_dir[1], t.az + ray_dir[2]};
        return t;
    endfunction

    task automatic random_phase(int count);
        repeat (count) send(random_tri());
        finish_burst();
    endtask

    initial
    begin
        board = new();
        sent = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        {vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
         vertex_c_x, vertex_c_y, vertex_c_z} = '0;
        ray_origin = '{32'd0, 32'd0, 32'd0};
        ray_dir = '{32'd0, 32'd0, DIR_Z_RESET};
        ray_eps = EPS_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset ray: origin at zero, looking along +z
        send({32'hFFFF0000, 32'hFFFF0000, 32'h00010000, 32'h00020000, 32'hFFFF0000,
              32'h00010000, 32'hFFFF0000, 32'h00020000, 32'h00010000});
        send({32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000, 32'h00020000, 32'hFFFF0000,
              32'hFFFF0000, 32'hFFFF0000, 32'h00020000, 32'hFFFF0000});
        send({32'h00010000, 32'h00010000, 32'h00010000, 32'h00030000, 32'h00010000,
              32'h00010000, 32'h00010000, 32'h00030000, 32'h00010000});
        send({32'h0, 32'h0, 32'h00010000, 32'h00010000, 32'h0, 32'h00010000,
              32'h0, 32'h00010000, 32'h00010000});
        send({32'hFFFF0000, 32'hFFFF0000, 32'h0, 32'h00020000, 32'hFFFF0000, 32'h0,
              32'hFFFF0000, 32'h00020000, 32'h0});
        send({32'h0, 32'h0, 32'h1, 32'h1, 32'h0, 32'h1, 32'h0, 32'h1, 32'h1});
        send({32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0, 32'h00020000, 32'h0, 32'h0});
        send({32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
              32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF});
        send({32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000});
        send({9{32'hFFFFFFFF}});
        send({9{32'h0}});
        finish_burst();

        // zero direction with zero epsilon: every triangle is parallel
        set_ray(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 64'd0);
        send({32'hFFFF0000, 32'hFFFF0000, 32'h00010000, 32'h00020000, 32'hFFFF0000,
              32'h00010000, 32'hFFFF0000, 32'h00020000, 32'h00010000});
        send({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        finish_burst();

        // extreme ray with maximal epsilon, then a mirrored extreme ray with zero epsilon
        set_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                32'h7FFFFFFF, 64'hFFFFFFFFFFFFFFFF);
        random_phase(40);
        set_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                32'h80000000, 64'd0);
        random_phase(60);

        set_ray(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, DIR_Z_RESET, 64'(EPS_RESET));
        random_phase(180);
        set_ray(near(1 << 12), near(1 << 12), 32'hFFF00000, 32'h0, 32'h0, 32'h00010000, 64'd0);
        random_phase(180);
        set_ray(near(1 << 16), near(1 << 16), near(1 << 16), near(1 << 17), near(1 << 17),
                near(1 << 17), {$urandom_range(0, 1) ? 32'd0 : $urandom, $urandom});
        random_phase(180);
        set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                {$urandom, $urandom});
        random_phase(150);
        set_ray(near(1 << 10), near(1 << 10), near(1 << 10), near(1 << 18), near(1 << 18),
                near(1 << 18), 64'd1);
        random_phase(150);

        settle();
        $display("%0d triangles sent, %0d outcomes checked over 9 ray settings", sent, board.seen);
        $display("parallel %0d, miss %0d, hit %0d", board.hits[0], board.hits[1], board.hits[2]);
        if (board.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
